### hw/rtl/vector_angle_cosine_core_defines.svh
// Assertion macros shared by the vector angle cosine core RTL.
// Used by files that check their own logic; no other dependencies.
`ifndef VECTOR_ANGLE_COSINE_CORE_DEFINES_SVH
`define VECTOR_ANGLE_COSINE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Checks a property on every clock edge outside reset.
`define VAC_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("vector angle cosine check failed");
// Checks that a condition is followed by another in the next cycle.
`define VAC_ASSERT_NEXT(label, cond, nxt) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (nxt)) \
        else $error("vector angle cosine sequence check failed");
`else
`define VAC_ASSERT(label, prop)
`define VAC_ASSERT_NEXT(label, cond, nxt)
`endif
`endif

### hw/rtl/vac_pkg.sv
// Package of the vector angle cosine core: widths and stage payload types.
// Used by every module of the core; depends on nothing.
`default_nettype none
package vac_pkg;
    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 14;
    localparam int N_COORD    = 12;
    localparam int IN_W       = ((N_COORD * COORD_BITS + 7) / 8) * 8;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int SQ_W       = 2 * DIFF_W;
    localparam int LEN_W      = SQ_W + 2;
    localparam int HALF_W     = LEN_W / 2;
    localparam int RAD_W      = 2 * LEN_W;
    localparam int ROOT_W     = LEN_W;
    localparam int REM_W      = ROOT_W + 2;
    localparam int DR_W       = ROOT_W + 1;
    localparam int Q_W        = FRAC_BITS + 1;
    localparam int COS_W      = FRAC_BITS + 2;
    localparam int OUT_W      = ((COS_W + 7) / 8) * 8;
    localparam int COS_ONE    = 1 << FRAC_BITS;

    // Item travelling down the square root chain.
    typedef struct packed {
        logic              valid;
        logic              null_err;
        logic              neg;
        logic [LEN_W-1:0]  mag;
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sqrt_stage_t;

    // Item travelling down the divider chain.
    typedef struct packed {
        logic              valid;
        logic              null_err;
        logic              neg;
        logic [ROOT_W-1:0] den;
        logic [DR_W-1:0]   rmd;
        logic [Q_W-1:0]    quo;
    } div_stage_t;
endpackage
`default_nettype wire

### hw/rtl/vac_front.sv
// Front stages: difference vectors, dot product, squared lengths and LA*LB.
// Depends on vac_pkg.
`default_nettype none
module vac_front (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 en,
    input  wire logic                 in_valid,
    input  wire logic [vac_pkg::IN_W-1:0] in_data,
    output vac_pkg::sqrt_stage_t      out_stage
);
    import vac_pkg::*;

    logic signed [COORD_BITS-1:0] crd [N_COORD];
    logic signed [DIFF_W-1:0] dif_next [6];
    logic signed [DIFF_W-1:0] dif_reg [6];
    logic signed [SQ_W-1:0] prd_reg [9];
    logic [LEN_W-1:0] la_reg, lb_reg;
    logic signed [LEN_W-1:0] dot_reg;
    logic [LEN_W-1:0] mag4_reg;
    logic neg4_reg, null4_reg;
    logic [LEN_W-1:0] pp_reg [4];
    logic [LEN_W-1:0] mag5_reg;
    logic neg5_reg, null5_reg;
    logic [RAD_W-1:0] rad_reg;
    logic [4:0] vld_reg;
    logic signed [LEN_W-1:0] dot_abs;

    // Unpack the coordinates, first field in the lowest bits.
    always_comb begin
        for (int i = 0; i < N_COORD; i++) begin
            crd[i] = in_data[i*COORD_BITS +: COORD_BITS];
        end
        for (int i = 0; i < 3; i++) begin
            dif_next[i]   = DIFF_W'(crd[3+i]) - DIFF_W'(crd[i]);
            dif_next[3+i] = DIFF_W'(crd[9+i]) - DIFF_W'(crd[6+i]);
        end
    end

    assign dot_abs = dot_reg[LEN_W-1] ? -dot_reg : dot_reg;

    // Valid bits of the five front stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    // Payload pipeline.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 6; i++) begin
                dif_reg[i] <= dif_next[i];
            end
            for (int i = 0; i < 3; i++) begin
                prd_reg[i]   <= dif_reg[i] * dif_reg[i];
                prd_reg[3+i] <= dif_reg[3+i] * dif_reg[3+i];
                prd_reg[6+i] <= dif_reg[i] * dif_reg[3+i];
            end
            la_reg  <= LEN_W'(unsigned'(prd_reg[0])) + LEN_W'(unsigned'(prd_reg[1]))
                     + LEN_W'(unsigned'(prd_reg[2]));
            lb_reg  <= LEN_W'(unsigned'(prd_reg[3])) + LEN_W'(unsigned'(prd_reg[4]))
                     + LEN_W'(unsigned'(prd_reg[5]));
            dot_reg <= LEN_W'(prd_reg[6]) + LEN_W'(prd_reg[7]) + LEN_W'(prd_reg[8]);
            // Split LA*LB into four half-width partial products.
            pp_reg[0] <= la_reg[HALF_W-1:0] * lb_reg[HALF_W-1:0];
            pp_reg[1] <= la_reg[HALF_W-1:0] * lb_reg[LEN_W-1:HALF_W];
            pp_reg[2] <= la_reg[LEN_W-1:HALF_W] * lb_reg[HALF_W-1:0];
            pp_reg[3] <= la_reg[LEN_W-1:HALF_W] * lb_reg[LEN_W-1:HALF_W];
            mag4_reg  <= unsigned'(dot_abs);
            neg4_reg  <= dot_reg[LEN_W-1];
            null4_reg <= (la_reg == '0) || (lb_reg == '0);
            rad_reg   <= RAD_W'(pp_reg[0]) + (RAD_W'(pp_reg[1]) << HALF_W)
                       + (RAD_W'(pp_reg[2]) << HALF_W) + (RAD_W'(pp_reg[3]) << LEN_W);
            mag5_reg  <= mag4_reg;
            neg5_reg  <= neg4_reg;
            null5_reg <= null4_reg;
        end
    end

    always_comb begin
        out_stage.valid    = vld_reg[4];
        out_stage.null_err = null5_reg;
        out_stage.neg      = neg5_reg;
        out_stage.mag      = mag5_reg;
        out_stage.rad      = rad_reg;
        out_stage.rem      = '0;
        out_stage.root     = '0;
    end
endmodule
`default_nettype wire

### hw/rtl/vac_sqrt_cell.sv
// One cell of the square root chain: settles one root bit per item.
// Depends on vac_pkg.
`default_nettype none
module vac_sqrt_cell (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           en,
    input  vac_pkg::sqrt_stage_t in_stage,
    output vac_pkg::sqrt_stage_t out_stage
);
    import vac_pkg::*;

    sqrt_stage_t stg_reg, stg_next;
    logic [REM_W-1:0] rem_sh, trial;

    // Bring down two radicand bits and try the next root bit.
    always_comb begin
        rem_sh   = {in_stage.rem[REM_W-3:0], in_stage.rad[RAD_W-1 -: 2]};
        trial    = {in_stage.root, 2'b01};
        stg_next = in_stage;
        stg_next.rad = {in_stage.rad[RAD_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
            stg_next.rem  = rem_sh - trial;
            stg_next.root = {in_stage.root[ROOT_W-2:0], 1'b1};
        end else begin
            stg_next.rem  = rem_sh;
            stg_next.root = {in_stage.root[ROOT_W-2:0], 1'b0};
        end
    end

    // Stage register; only the valid bit is reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_reg.valid <= 1'b0;
        end else if (en) begin
            stg_reg.valid <= stg_next.valid;
        end
        if (en) begin
            stg_reg.null_err <= stg_next.null_err;
            stg_reg.neg      <= stg_next.neg;
            stg_reg.mag      <= stg_next.mag;
            stg_reg.rad      <= stg_next.rad;
            stg_reg.rem      <= stg_next.rem;
            stg_reg.root     <= stg_next.root;
        end
    end

    assign out_stage = stg_reg;
endmodule
`default_nettype wire

### hw/rtl/vac_div_cell.sv
// One cell of the restoring divider chain: settles one quotient bit.
// Depends on vac_pkg.
`default_nettype none
module vac_div_cell (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          en,
    input  vac_pkg::div_stage_t in_stage,
    output vac_pkg::div_stage_t out_stage
);
    import vac_pkg::*;

    div_stage_t stg_reg, stg_next;
    logic [DR_W-1:0] rest;
    logic bit_q;

    // Compare and subtract, then shift the remainder for the next bit.
    always_comb begin
        bit_q = (in_stage.rmd >= {1'b0, in_stage.den});
        rest  = bit_q ? (in_stage.rmd - {1'b0, in_stage.den}) : in_stage.rmd;
        stg_next     = in_stage;
        stg_next.rmd = {rest[DR_W-2:0], 1'b0};
        stg_next.quo = {in_stage.quo[Q_W-2:0], bit_q};
    end

    // Stage register; only the valid bit is reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_reg.valid <= 1'b0;
        end else if (en) begin
            stg_reg.valid <= stg_next.valid;
        end
        if (en) begin
            stg_reg.null_err <= stg_next.null_err;
            stg_reg.neg      <= stg_next.neg;
            stg_reg.den      <= stg_next.den;
            stg_reg.rmd      <= stg_next.rmd;
            stg_reg.quo      <= stg_next.quo;
        end
    end

    assign out_stage = stg_reg;
endmodule
`default_nettype wire

### hw/rtl/vector_angle_cosine_core.sv
// Top level of the vector angle cosine core: front stages, root and divider chains.
// Depends on vac_pkg, vac_front, vac_sqrt_cell, vac_div_cell and the defines header.
//
// Channel  Direction  tdata                                      tuser
// s_       in         a_start_x..b_end_z, 16 bits each           -
// m_       out        cosine (Q1.14)                             null_error
//
// One item is accepted per cycle while the output is not stalled; the path runs
// through 5 front stages, one cell per root bit, one cell per quotient bit and the
// output register.
// The whole pipeline moves when the output register is empty or being taken.
// Reset clears only the valid bits of the stages.
`include "vector_angle_cosine_core_defines.svh"
`default_nettype none
module vector_angle_cosine_core (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    // a_start_x, a_start_y, a_start_z, a_end_x, a_end_y, a_end_z,
    // b_start_x, b_start_y, b_start_z, b_end_x, b_end_y, b_end_z
    input  wire logic [vac_pkg::IN_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    // cosine
    output logic [vac_pkg::OUT_W-1:0]      m_tdata,
    // null_error
    output logic                           m_tuser
);
    import vac_pkg::*;

    logic en;
    sqrt_stage_t sq_chain [ROOT_W+1];
    div_stage_t  dv_chain [Q_W+1];
    logic [Q_W-1:0] q_clamp;
    logic [COS_W-1:0] cos_next;
    logic m_tvalid_reg;
    logic [COS_W-1:0] cos_reg;
    logic null_reg;
    logic signed [COS_W-1:0] cos_sgn;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    vac_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_data   (s_tdata),
        .out_stage (sq_chain[0])
    );

    // Square root chain, one cell per root bit.
    for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
        vac_sqrt_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_stage  (sq_chain[g]),
            .out_stage (sq_chain[g+1])
        );
    end

    // Hand the root over as divisor.
    always_comb begin
        dv_chain[0].valid    = sq_chain[ROOT_W].valid;
        dv_chain[0].null_err = sq_chain[ROOT_W].null_err;
        dv_chain[0].neg      = sq_chain[ROOT_W].neg;
        dv_chain[0].den      = sq_chain[ROOT_W].root;
        dv_chain[0].rmd      = {1'b0, sq_chain[ROOT_W].mag};
        dv_chain[0].quo      = '0;
    end

    // Divider chain, one cell per quotient bit.
    for (genvar g = 0; g < Q_W; g++) begin : g_div
        vac_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_stage  (dv_chain[g]),
            .out_stage (dv_chain[g+1])
        );
    end

    // Clamp to one, apply the sign, force zero for a null vector.
    always_comb begin
        q_clamp = dv_chain[Q_W].quo;
        if (q_clamp > (Q_W'(1) << FRAC_BITS)) begin
            q_clamp = Q_W'(1) << FRAC_BITS;
        end
        if (dv_chain[Q_W].null_err) begin
            cos_next = '0;
        end else if (dv_chain[Q_W].neg) begin
            cos_next = -{1'b0, q_clamp};
        end else begin
            cos_next = {1'b0, q_clamp};
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= dv_chain[Q_W].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cos_reg  <= cos_next;
            null_reg <= dv_chain[Q_W].null_err;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_W'(cos_reg);
    assign m_tuser  = null_reg;
    assign cos_sgn  = cos_reg;

    `VAC_ASSERT(a_null_zero, !(m_tvalid_reg && null_reg) || (cos_reg == '0))
    `VAC_ASSERT(a_cos_range, !m_tvalid_reg || (cos_sgn <= COS_ONE && cos_sgn >= -COS_ONE))
    `VAC_ASSERT_NEXT(a_drain, m_tvalid_reg && m_tready && !dv_chain[Q_W].valid, !m_tvalid_reg)
endmodule
`default_nettype wire

### test/testbench.sv
// Self-checking testbench of the vector angle cosine core.
// Depends on vac_pkg and vector_angle_cosine_core; predicts each cosine and checks it in order.
`timescale 1ns / 100ps
`default_nettype none

// Holds the predicted cosines in arrival order and checks each result item.
class cosine_scoreboard;
    logic [vac_pkg::COS_W-1:0] cos_q[$];
    logic                      err_q[$];
    int                        failures = 0;
    int                        checked  = 0;
    int                        nulls    = 0;

    // Works out the expected cosine of one accepted input item.
    function void note_input(logic [vac_pkg::IN_W-1:0] data);
        logic signed [vac_pkg::COORD_BITS-1:0] c[12];
        logic signed [63:0] da[3];
        logic signed [63:0] db[3];
        logic signed [63:0] dot;
        logic [127:0] prod;
        logic [127:0] cand;
        logic [63:0] len_a;
        logic [63:0] len_b;
        logic [63:0] root;
        logic [63:0] mag;
        logic [63:0] quo;
        logic [63:0] rmd;
        dot = 0;
        len_a = 0;
        len_b = 0;
        for (int i = 0; i < 12; i++)
            c[i] = data[i*vac_pkg::COORD_BITS +: vac_pkg::COORD_BITS];
        for (int i = 0; i < 3; i++) begin
            da[i] = 64'(c[3+i]) - 64'(c[i]);
            db[i] = 64'(c[9+i]) - 64'(c[6+i]);
            len_a += da[i] * da[i];
            len_b += db[i] * db[i];
            dot += da[i] * db[i];
        end
        if (len_a == 0 || len_b == 0) begin
            cos_q.push_back('0);
            err_q.push_back(1'b1);
            return;
        end
        // Integer square root of the full-width product, bit by bit.
        prod = 128'(len_a) * 128'(len_b);
        root = 0;
        for (int b = 53; b >= 0; b--) begin
            cand = 128'(root | (64'd1 << b));
            if (cand * cand <= prod)
                root = root | (64'd1 << b);
        end
        mag = (dot < 0) ? 64'(-dot) : 64'(dot);
        quo = mag / root;
        rmd = mag % root;
        for (int k = 0; k < vac_pkg::FRAC_BITS; k++) begin
            rmd = rmd << 1;
            quo = quo << 1;
            if (rmd >= root) begin
                rmd -= root;
                quo |= 1;
            end
        end
        if (quo > (64'd1 << vac_pkg::FRAC_BITS))
            quo = 64'd1 << vac_pkg::FRAC_BITS;
        cos_q.push_back((dot < 0) ? vac_pkg::COS_W'(-quo) : vac_pkg::COS_W'(quo));
        err_q.push_back(1'b0);
    endfunction

    // Compares one result item with the oldest prediction.
    function void check_result(logic [vac_pkg::OUT_W-1:0] data, logic user);
        logic [vac_pkg::COS_W-1:0] exp_cos;
        logic                      exp_err;
        if (cos_q.size() == 0) begin
            $error("result item with no prediction waiting: cosine %h", data);
            failures++;
            return;
        end
        exp_cos = cos_q.pop_front();
        exp_err = err_q.pop_front();
        checked++;
        if (exp_err)
            nulls++;
        if (data !== vac_pkg::OUT_W'(exp_cos)) begin
            $error("cosine: expected %h, actual %h", exp_cos, data);
            failures++;
        end
        if (user !== exp_err) begin
            $error("null_error: expected %b, actual %b", exp_err, user);
            failures++;
        end
    endfunction
endclass

module testbench;
    localparam int LATENCY = 57;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [vac_pkg::IN_W-1:0] s_tdata = '0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [vac_pkg::OUT_W-1:0] m_tdata;
    logic                     m_tuser;
    logic                     calm = 1'b0;
    int                       sent = 0;
    cosine_scoreboard         sb = new();

    vector_angle_cosine_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #5 aclk = ~aclk;

    // Receiver: random stalls except in the calm stretch; checks every result item.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
        m_tready <= calm || ($urandom_range(99) >= 26);
    end

    // Picks one coordinate, favouring the extremes now and then.
    function automatic logic [15:0] pick_coord();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom_range(15)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    // Sends one input item, idling at random beforehand unless calm.
    task automatic send_item(logic [vac_pkg::IN_W-1:0] data);
        while (!calm && $urandom_range(99) < 26) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sb.note_input(data);
        sent++;
    endtask

    // Builds an item from two vectors given by start and end points.
    function automatic logic [vac_pkg::IN_W-1:0] pack_pair(
        logic [15:0] as[3], logic [15:0] ae[3], logic [15:0] bs[3], logic [15:0] be[3]);
        logic [vac_pkg::IN_W-1:0] d;
        d = '0;
        for (int i = 0; i < 3; i++) begin
            d[i*16 +: 16]      = as[i];
            d[(3+i)*16 +: 16]  = ae[i];
            d[(6+i)*16 +: 16]  = bs[i];
            d[(9+i)*16 +: 16]  = be[i];
        end
        return d;
    endfunction

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.cos_q.size() != 0)
            @(posedge aclk);
    endtask

    initial begin
        logic [15:0] as[3];
        logic [15:0] ae[3];
        logic [15:0] bs[3];
        logic [15:0] be[3];
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed items: zero vectors, parallel, opposite, orthogonal, extreme spans.
        send_item(pack_pair('{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}, '{1, 2, 3}));
        send_item(pack_pair('{0, 0, 0}, '{1, 2, 3}, '{5, 5, 5}, '{5, 5, 5}));
        send_item(pack_pair('{7, 7, 7}, '{7, 7, 7}, '{9, 9, 9}, '{9, 9, 9}));
        send_item(pack_pair('{0, 0, 0}, '{1, 2, 3}, '{0, 0, 0}, '{2, 4, 6}));
        send_item(pack_pair('{0, 0, 0}, '{1, 2, 3}, '{0, 0, 0}, '{-2, -4, -6}));
        send_item(pack_pair('{0, 0, 0}, '{1, 0, 0}, '{0, 0, 0}, '{0, 1, 0}));
        send_item(pack_pair('{16'h8000, 16'h8000, 16'h8000}, '{16'h7fff, 16'h7fff, 16'h7fff},
                            '{16'h8000, 16'h8000, 16'h8000}, '{16'h7fff, 16'h7fff, 16'h7fff}));
        send_item(pack_pair('{16'h8000, 16'h8000, 16'h8000}, '{16'h7fff, 16'h7fff, 16'h7fff},
                            '{16'h7fff, 16'h7fff, 16'h7fff}, '{16'h8000, 16'h8000, 16'h8000}));
        send_item(pack_pair('{16'h7fff, 0, 0}, '{16'h8000, 0, 0}, '{0, 0, 0}, '{1, 1, 0}));
        send_item(pack_pair('{0, 0, 0}, '{1, 1, 1}, '{0, 0, 0}, '{1, 1, 0}));
        send_item(pack_pair('{0, 16'h8000, 0}, '{0, 16'h7fff, 1}, '{3, 0, 16'h8000},
                            '{0, 4, 16'h7fff}));
        send_item(pack_pair('{16'hffff, 16'hffff, 16'hffff}, '{0, 0, 0},
                            '{16'hffff, 0, 16'hffff}, '{0, 16'hffff, 0}));

        // Hold off until every prediction has been met.
        wait_drained();

        // Random items with a calm stretch in the middle.
        for (int n = 0; n < 1700; n++) begin
            calm <= (n >= 600 && n < 800);
            for (int i = 0; i < 3; i++) begin
                as[i] = pick_coord();
                ae[i] = ($urandom_range(19) == 0) ? as[i] : pick_coord();
                bs[i] = pick_coord();
                be[i] = pick_coord();
            end
            if ($urandom_range(29) == 0)
                be = bs;
            send_item(pack_pair(as, ae, bs, be));
        end
        calm <= 1'b0;
        wait_drained();
        repeat (LATENCY + 10) @(posedge aclk);

        $display("Sent %0d items, checked %0d results, %0d with a zero-length vector.",
                 sent, sb.checked, sb.nulls);
        if (sb.failures == 0 && sb.cos_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog on the whole run.
    initial begin
        #2ms;
        $display("== FAIL ==");
        $finish;
    end
endmodule
`default_nettype wire
